// ===== rtl/core/hbf_pkg.sv =====
// Shared types and constants for the 3x3 heightmap box filter.
// Frame geometry, payload structs and fixed-point reciprocals.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbf_pkg;

  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;

  localparam int COL_W    = $clog2(IMAGE_WIDTH);
  localparam int ROW_W    = $clog2(IMAGE_HEIGHT);
  // input row runs up to two rows past the frame while draining
  localparam int IN_ROW_W = $clog2(IMAGE_HEIGHT + 2);

  localparam int SAMPLE_W = 8;
  localparam int MEAN_W   = 16;
  localparam int POS_W    = 8;
  localparam int TAPS     = 9;
  localparam int CENTER_TAP = 4;

  // 9 * 255 fits in 12 bits; scaled sum fits in 20 bits
  localparam int SUM_W       = 12;
  localparam int MEAN_X_W    = 20;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 23;

  // ceil(2^23 / d): exact floor division for dividends below 2^20
  localparam logic [RECIP_W-1:0] RECIP_ONE   = 24'd8388608;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = 24'd2796203;
  localparam logic [RECIP_W-1:0] RECIP_NINTH = 24'd932068;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_e;

  // register index taken from the word address bit
  typedef enum logic {
    REG_SMOOTH_EDGES = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_value;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              frame_last;
  } out_item_t;

  // one line store entry: two rows back (top) and one row back (mid)
  typedef struct packed {
    logic [SAMPLE_W-1:0] top;
    logic [SAMPLE_W-1:0] mid;
  } line_pair_t;

  typedef logic [SAMPLE_W-1:0] tap_t;
  typedef tap_t [TAPS-1:0] taps_t;

  // which neighbors of the output pixel lie inside the frame
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } border_t;

endpackage

`default_nettype wire

// ===== rtl/core/hbf_line_store.sv =====
// Line store: both previous rows packed into one entry per column.
// Synchronous RAM with registered read, one read and one write port.
// Depends on hbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbf_line_store
  import hbf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [COL_W-1:0] rd_addr_i,
  output line_pair_t            rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [COL_W-1:0] wr_addr_i,
  input  line_pair_t            wr_data_i
);

  line_pair_t mem_q [IMAGE_WIDTH];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/hbf_mean_unit.sv =====
// Window mean: masked tap sum, divisor select, reciprocal multiply.
// Sum and reciprocal are registered; the product feeds the output register.
// Depends on hbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbf_mean_unit
  import hbf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic              smooth_i,
  input  border_t                border_i,
  input  taps_t                  taps_i,
  output logic [MEAN_W-1:0]      mean_o
);

  logic [2:0]                  row_ok;
  logic [2:0]                  col_ok;
  logic [SUM_W-1:0]            sum;
  logic                        inner;
  logic                        rows3;
  logic                        cols3;
  logic [MEAN_X_W-1:0]         x_d;
  logic [RECIP_W-1:0]          recip_d;
  logic [MEAN_X_W-1:0]         x_q;
  logic [RECIP_W-1:0]          recip_q;
  logic [MEAN_X_W+RECIP_W-1:0] prod;

  assign row_ok = {border_i.bot, 1'b1, border_i.top};
  assign col_ok = {border_i.rgt, 1'b1, border_i.lft};
  assign inner  = &border_i;
  assign rows3  = border_i.top & border_i.bot;
  assign cols3  = border_i.lft & border_i.rgt;

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum = sum + SUM_W'(taps_i[r*3+c]);
        end
      end
    end
  end

  // count 4 -> shift only, count 6 -> half then /3, count 9 -> /9; unsmoothed edge -> centre tap
  always_comb begin
    priority if (!smooth_i && !inner) begin
      x_d     = MEAN_X_W'({taps_i[CENTER_TAP], 8'b0});
      recip_d = RECIP_ONE;
    end else if (rows3 && cols3) begin
      x_d     = {sum, 8'b0};
      recip_d = RECIP_NINTH;
    end else if (rows3 || cols3) begin
      x_d     = MEAN_X_W'({sum, 7'b0});
      recip_d = RECIP_THIRD;
    end else begin
      x_d     = MEAN_X_W'({sum, 6'b0});
      recip_d = RECIP_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q     <= x_d;
      recip_q <= recip_d;
    end
  end

  assign prod   = x_q * recip_q;
  assign mean_o = prod[RECIP_SHIFT +: MEAN_W];

endmodule

`default_nettype wire

// ===== rtl/core/heightmap_box_filter_3x3.sv =====
// Top level of the 3x3 heightmap box filter: handshakes, config register,
// sequencer, window taps and raster counters. Uses hbf_line_store,
// hbf_mean_unit and hbf_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | sink      | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | source    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg     | sink      | psel/penable/pready     | paddr, pwdata, prdata
//
// A transaction that yields a result goes through accept with line store read,
// read-modify-write of the line store entry, sum, and multiply into the output
// register. Others end after read-modify-write; ignored flushes at acceptance.
// The sequencer takes one transaction at a time; that sets the pace.
// Reset clears counters, taps and the output register; no clearing pass.
// A stalled output holds the next result in the multiply step and stalls input.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_box_filter_3x3
  import hbf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SUM,
    ST_MUL
  } state_e;

  state_e                state_q, state_d;
  logic [COL_W-1:0]      in_col_q, in_col_d;
  logic [IN_ROW_W-1:0]   in_row_q, in_row_d;
  logic [COL_W-1:0]      out_col_q, out_col_d;
  logic [ROW_W-1:0]      out_row_q, out_row_d;
  taps_t                 taps_q, taps_d;
  logic [SAMPLE_W-1:0]   sample_q, sample_d;
  logic                  smooth_q, smooth_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_data_q, out_data_d;

  logic                  in_accept;
  logic                  drain;
  logic                  flush_ignored;
  logic                  emit;
  logic                  frame_last;
  logic                  mul_load;
  logic                  cfg_write;
  logic                  line_rd_en;
  logic                  line_wr_en;
  line_pair_t            line_rd_data;
  line_pair_t            line_wr_data;
  logic                  mean_load;
  border_t               border;
  logic [MEAN_W-1:0]     mean;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign drain         = (in_row_q >= IN_ROW_W'(IMAGE_HEIGHT));
  assign flush_ignored = !drain && (in_data_i.opcode == OP_FLUSH);
  assign line_rd_en    = in_accept && !flush_ignored;
  assign emit          = (in_row_q >= IN_ROW_W'(2)) ||
                         ((in_row_q == IN_ROW_W'(1)) && (in_col_q != '0));
  assign frame_last    = (out_row_q == ROW_W'(IMAGE_HEIGHT - 1)) &&
                         (out_col_q == COL_W'(IMAGE_WIDTH - 1));
  assign mul_load      = (state_q == ST_MUL) && (!out_valid_q || !out_stall_i);
  assign line_wr_data  = '{top: line_rd_data.mid, mid: sample_q};

  assign border = '{top: (out_row_q != '0),
                    bot: (out_row_q != ROW_W'(IMAGE_HEIGHT - 1)),
                    lft: (out_col_q != '0),
                    rgt: (out_col_q != COL_W'(IMAGE_WIDTH - 1))};

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_SMOOTH_EDGES) ? PDATA_W'(smooth_q) : '0;

  // The entry read at acceptance is written back in the next cycle, in ST_RMW; only one
  // transaction is in the read-modify-write window, so no forwarding needed.
  hbf_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (line_rd_en),
    .rd_addr_i (in_col_q),
    .rd_data_o (line_rd_data),
    .wr_en_i   (line_wr_en),
    .wr_addr_i (in_col_q),
    .wr_data_i (line_wr_data)
  );

  hbf_mean_unit u_mean_unit (
    .clk_i    (clk_i),
    .load_i   (mean_load),
    .smooth_i (smooth_q),
    .border_i (border),
    .taps_i   (taps_q),
    .mean_o   (mean)
  );

  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    taps_d      = taps_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    line_wr_en  = 1'b0;
    mean_load   = 1'b0;
    smooth_d    = (cfg_write && (paddr[2] == REG_SMOOTH_EDGES)) ? pwdata[0] : smooth_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && !flush_ignored) begin
          // past the last row every transaction drains with a zero sample
          sample_d = drain ? '0 : in_data_i.sample;
          state_d  = ST_RMW;
        end
      end
      ST_RMW: begin
        line_wr_en = 1'b1;
        for (int r = 0; r < 3; r++) begin
          taps_d[r*3]   = taps_q[r*3+1];
          taps_d[r*3+1] = taps_q[r*3+2];
        end
        taps_d[2] = line_rd_data.top;
        taps_d[5] = line_rd_data.mid;
        taps_d[8] = sample_q;
        if (in_col_q == COL_W'(IMAGE_WIDTH - 1)) begin
          in_col_d = '0;
          in_row_d = in_row_q + IN_ROW_W'(1);
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
        state_d = emit ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        mean_load = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_load) begin
          out_valid_d           = 1'b1;
          out_data_d.mean_value = mean;
          out_data_d.column     = POS_W'(out_col_q);
          out_data_d.row        = POS_W'(out_row_q);
          out_data_d.frame_last = frame_last;
          if (frame_last) begin
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
            out_row_d = '0;
            taps_d    = '0;
          end else if (out_col_q == COL_W'(IMAGE_WIDTH - 1)) begin
            out_col_d = '0;
            out_row_d = out_row_q + ROW_W'(1);
          end else begin
            out_col_d = out_col_q + COL_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      taps_q      <= '0;
      sample_q    <= '0;
      smooth_q    <= 1'b1;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      taps_q      <= taps_d;
      sample_q    <= sample_d;
      smooth_q    <= smooth_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // the frame's last result always carries the bottom-right position
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_last |->
      (out_data_o.column == POS_W'(IMAGE_WIDTH - 1)) &&
      (out_data_o.row == POS_W'(IMAGE_HEIGHT - 1)))
    else $error("frame_last on a pixel other than the last one");

  // after the last result both raster positions restart at the origin
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_load && frame_last |=>
      (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
    else $error("counters not cleared at end of frame");

  // draining never runs beyond one row plus one pixel
  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_row_q <= IN_ROW_W'(IMAGE_HEIGHT + 1)) &&
      ((in_row_q != IN_ROW_W'(IMAGE_HEIGHT + 1)) || (in_col_q <= COL_W'(1))))
    else $error("input position ran past the drain window");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_heightmap_box_filter_3x3.sv =====
// Self-checking bench for heightmap_box_filter_3x3: raster pixel stream,
// flushes inside a frame, edge smoothing switched over APB. Needs hbf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_heightmap_box_filter_3x3
  import hbf_pkg::*;
();

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP     = 30;
  localparam int RANDOM_SEGS   = 4;
  localparam int SEG_PIXELS    = 120;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_item_t            in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_item_t           out_data_o;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  heightmap_box_filter_3x3 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Filter predictor: own line stores, window and raster counters
  // ---------------------------------------------------------------------
  tap_t      older_line [IMAGE_WIDTH];  // two rows back
  tap_t      newer_line [IMAGE_WIDTH];  // one row back
  tap_t      window_px  [TAPS];
  int        feed_col, feed_row, emit_col, emit_row;
  bit        smooth_cfg;
  out_item_t awaited_pixels [$];
  int        mismatches  = 0;
  bit        steady_flow = 1'b0;

  function automatic void clear_frame();
    foreach (window_px[i]) window_px[i] = '0;
    feed_col = 0;
    feed_row = 0;
    emit_col = 0;
    emit_row = 0;
  endfunction

  function automatic void reset_filter_model();
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    clear_frame();
    smooth_cfg = 1'b1;
  endfunction

  function automatic logic [MEAN_W-1:0] box_mean();
    bit          has_up, has_dn, has_lf, has_rt;
    int unsigned sum, cnt;
    has_up = emit_row > 0;
    has_dn = emit_row < IMAGE_HEIGHT - 1;
    has_lf = emit_col > 0;
    has_rt = emit_col < IMAGE_WIDTH - 1;
    if (!smooth_cfg && !(has_up && has_dn && has_lf && has_rt))
      return {window_px[CENTER_TAP], 8'h00};
    sum = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r != 0 || has_up) && (r != 2 || has_dn) && (c != 0 || has_lf) && (c != 2 || has_rt))
          sum += window_px[3*r + c];
      end
    end
    cnt = (1 + has_up + has_dn) * (1 + has_lf + has_rt);
    return MEAN_W'((sum << 8) / cnt);
  endfunction

  // Advances the model by one accepted item; returns 1 when a pixel comes out.
  function automatic bit box_filter_step(input in_item_t it, output out_item_t px);
    bit   draining, produces;
    tap_t s, up, mid;
    px = '0;
    draining = feed_row >= IMAGE_HEIGHT;
    if (!draining && it.opcode == OP_FLUSH) return 1'b0;
    s   = draining ? tap_t'(0) : it.sample;
    up  = older_line[feed_col];
    mid = newer_line[feed_col];
    older_line[feed_col] = mid;
    newer_line[feed_col] = s;
    for (int r = 0; r < 3; r++) begin
      window_px[3*r]     = window_px[3*r + 1];
      window_px[3*r + 1] = window_px[3*r + 2];
    end
    window_px[2] = up;
    window_px[5] = mid;
    window_px[8] = s;
    produces = feed_row >= 2 || (feed_row == 1 && feed_col >= 1);
    feed_col++;
    if (feed_col >= IMAGE_WIDTH) begin
      feed_col = 0;
      feed_row++;
    end
    if (!produces) return 1'b0;
    px.mean_value = box_mean();
    px.column     = emit_col[POS_W-1:0];
    px.row        = emit_row[POS_W-1:0];
    px.frame_last = emit_row == IMAGE_HEIGHT - 1 && emit_col == IMAGE_WIDTH - 1;
    if (px.frame_last) begin
      clear_frame();
    end else begin
      emit_col++;
      if (emit_col >= IMAGE_WIDTH) begin
        emit_col = 0;
        emit_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall, compare against the oldest awaited pixel
  // ---------------------------------------------------------------------
  out_item_t want_px;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel: mean %h col %0d row %0d last %b",
                      out_data_o.mean_value, out_data_o.column, out_data_o.row,
                      out_data_o.frame_last));
      end else begin
        want_px = awaited_pixels.pop_front();
        if (out_data_o.mean_value !== want_px.mean_value || out_data_o.column !== want_px.column ||
            out_data_o.row !== want_px.row || out_data_o.frame_last !== want_px.frame_last)
          flag_mismatch($sformatf("pixel got mean %h col %0d row %0d last %b, want %h %0d %0d %b",
                        out_data_o.mean_value, out_data_o.column, out_data_o.row,
                        out_data_o.frame_last, want_px.mean_value, want_px.column,
                        want_px.row, want_px.frame_last));
      end
    end
    out_stall_i <= !steady_flow && ($urandom_range(99) < 38);
  end

  // no transaction on either channel for too long: give up
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Input side and config port
  // ---------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit typed, input logic [MEAN_W-1:0] mean);
    out_item_t px;
    while (!steady_flow && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (box_filter_step(it, px)) begin
      if (typed) px.mean_value = mean;
      awaited_pixels = {awaited_pixels, px};
    end
  endtask

  // n pixel samples inside the frame, with a few flushes mixed in as noise
  task automatic send_random_pixels(input int n);
    in_item_t it;
    int       sent;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0:       it.sample = 8'h00;
        1:       it.sample = 8'hFF;
        default: it.sample = SAMPLE_W'($urandom_range(255));
      endcase
      if ($urandom_range(99) < 4) begin
        it.opcode = OP_FLUSH;
      end else begin
        it.opcode = OP_SAMPLE;
        sent++;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input reg_idx_e idx, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_readback();
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b0, REG_SMOOTH_EDGES, '0, rd);
    if (rd !== PDATA_W'(smooth_cfg))
      flag_mismatch($sformatf("smooth_edges reads %h, want %0d", rd, smooth_cfg));
  endtask

  task automatic set_smoothing(input bit on);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, REG_SMOOTH_EDGES, PDATA_W'(on), rd);
    smooth_cfg = on;
    check_readback();
  endtask

  // ---------------------------------------------------------------------
  // Directed rows: start of a frame with smoothing on (reset value).
  // Typed means hold where every in-frame neighbor is 255.
  // ---------------------------------------------------------------------
  typedef struct packed {
    opcode_e             op;
    logic [SAMPLE_W-1:0] sample;
    logic [9:0]          reps;
    logic                typed;
    logic [MEAN_W-1:0]   mean;
  } dir_row_t;

  dir_row_t directed_rows [10] = '{
    '{OP_FLUSH,  8'hFF, 10'd1,   1'b0, 16'h0000},  // flush right after reset: ignored
    '{OP_SAMPLE, 8'hFF, 10'd256, 1'b0, 16'h0000},  // row 0, nothing comes out yet
    '{OP_SAMPLE, 8'hFF, 10'd256, 1'b1, 16'hFF00},  // row 0 results, incl. the top-left corner
    '{OP_FLUSH,  8'h00, 10'd2,   1'b0, 16'h0000},  // flush inside a frame: ignored
    '{OP_SAMPLE, 8'hFF, 10'd256, 1'b1, 16'hFF00},
    '{OP_SAMPLE, 8'h00, 10'd256, 1'b0, 16'h0000},
    '{OP_SAMPLE, 8'h55, 10'd1,   1'b0, 16'h0000},
    '{OP_SAMPLE, 8'hAA, 10'd1,   1'b0, 16'h0000},
    '{OP_SAMPLE, 8'h01, 10'd1,   1'b0, 16'h0000},
    '{OP_SAMPLE, 8'h80, 10'd1,   1'b0, 16'h0000}
  };

  initial begin
    in_item_t it;

    reset_filter_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_readback();

    foreach (directed_rows[i]) begin
      it.opcode = directed_rows[i].op;
      it.sample = directed_rows[i].sample;
      repeat (directed_rows[i].reps) send_item(it, directed_rows[i].typed, directed_rows[i].mean);
    end

    // random samples in segments, smoothing toggled in between; one segment without idling
    for (int seg = 0; seg < RANDOM_SEGS; seg++) begin
      quiesce();
      set_smoothing(seg % 2 == 1);
      steady_flow = (seg == 1);
      send_random_pixels(SEG_PIXELS);
    end
    steady_flow = 1'b0;

    quiesce();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
